// ----- rtl/kee_pkg.sv -----
// Shared types, key tables and constants for the keypad edge event encoder.
package kee_pkg;

    localparam int KEY_COUNT = 12;

    // Per-unit state word held in the state memory
    typedef struct packed {
        logic [11:0] pressed;
        logic [2:0]  serial;
        logic [31:0] edge_word;
        logic [15:0] level_word;
    } t_unit_state;

    typedef enum logic [0:0] {
        CFG_FLIP_ROWS = 1'b0,
        CFG_FREEZE    = 1'b1
    } t_cfg_index;

    localparam logic [7:0] EDGE_FLAG = 8'h80;

    // Raw bit looked at for each key
    localparam logic [3:0] RAW_BIT [KEY_COUNT] = '{
        4'd0, 4'd1, 4'd5, 4'd9, 4'd2, 4'd6, 4'd10, 4'd3, 4'd7, 4'd11, 4'd8, 4'd4
    };

    localparam logic [15:0] KEY_CODE [KEY_COUNT] = '{
        16'h0100, 16'h0200, 16'h2000, 16'h0002, 16'h0400, 16'h4000,
        16'h0004, 16'h0800, 16'h8000, 16'h0008, 16'h0001, 16'h1000
    };

    localparam logic [3:0] KEY_NUMBER [KEY_COUNT] = '{
        4'd0, 4'd1, 4'd5, 4'd9, 4'd2, 4'd6, 4'd10, 4'd3, 4'd7, 4'd11, 4'd8, 4'd4
    };

    // Key read by each scan slot when rows are swapped
    localparam logic [3:0] FLIP_KEY [KEY_COUNT] = '{
        4'd11, 4'd7, 4'd8, 4'd9, 4'd4, 4'd5, 4'd6, 4'd1, 4'd2, 4'd3, 4'd10, 4'd0
    };

endpackage

// ----- rtl/kee_state_mem.sv -----
// Per-unit state memory: one write port, one registered read port with bypass.
module kee_state_mem #(
    parameter int NUM_UNITS = 2,
    parameter int AW        = 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_rd_en,
    input  logic [AW-1:0]        i_rd_addr,
    output kee_pkg::t_unit_state o_rd_data,
    input  logic                 i_wr_en,
    input  logic [AW-1:0]        i_wr_addr,
    input  kee_pkg::t_unit_state i_wr_data
);
    import kee_pkg::*;

    t_unit_state          r_mem [NUM_UNITS];
    logic [NUM_UNITS-1:0] r_valid;
    t_unit_state          r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr_en) begin
            r_valid[i_wr_addr] <= 1'b1;
        end
    end

    // write in the same cycle as a read of that entry is passed straight through
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            if (i_wr_en && (i_wr_addr == i_rd_addr)) begin
                r_rd_data <= i_wr_data;
            end else if (r_valid[i_rd_addr]) begin
                r_rd_data <= r_mem[i_rd_addr];
            end else begin
                r_rd_data <= '0;
            end
        end
    end

    assign o_rd_data = r_rd_data;

    a_bypass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rd_en && i_wr_en && (i_rd_addr == i_wr_addr) |=> o_rd_data == $past(i_wr_data))
        else $error("state bypass lost a write");

    a_valid_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_wr_en |=> r_valid[$past(i_wr_addr)])
        else $error("entry not marked valid after write");

endmodule

// ----- rtl/kee_scan.sv -----
// Key scan: level word, new-press detection and edge word update for one poll.
module kee_scan (
    input  logic                 i_flip,
    input  logic [11:0]          i_keys,
    input  kee_pkg::t_unit_state i_state,
    output kee_pkg::t_unit_state o_state
);
    import kee_pkg::*;

    logic [3:0]  slot_key;
    logic [11:0] slot_pr;
    logic [11:0] slot_new;
    logic [11:0] now_pr;
    logic [15:0] level;
    logic [3:0]  new_cnt;
    logic        any_new;
    logic [3:0]  last_slot;
    logic [15:0] clr_mask;
    logic [2:0]  serial_nx;
    logic [2:0]  serial_last;
    logic [15:0] edge_hi;
    logic [15:0] edge_lo;

    always_comb begin
        slot_key = '0;
        slot_pr  = '0;
        slot_new = '0;
        now_pr   = '0;
        level    = '0;
        new_cnt  = '0;
        any_new  = 1'b0;
        last_slot = '0;
        clr_mask = '0;

        // pressed flags and level are indexed by key read, not by slot
        for (int k = 0; k < KEY_COUNT; k++) begin
            now_pr[k] = i_keys[RAW_BIT[k]];
            if (now_pr[k]) begin
                level = level | KEY_CODE[k];
            end
        end

        for (int n = 0; n < KEY_COUNT; n++) begin
            slot_key    = i_flip ? FLIP_KEY[n] : 4'(n);
            slot_pr[n]  = now_pr[slot_key];
            slot_new[n] = now_pr[slot_key] & ~i_state.pressed[slot_key];
            new_cnt     = new_cnt + 4'(slot_new[n]);
        end

        for (int n = 0; n < KEY_COUNT; n++) begin
            if (slot_new[n]) begin
                any_new   = 1'b1;
                last_slot = 4'(n);
            end
        end

        // released slots after the last new press (every released slot if there is none) clear their code bit
        for (int n = 0; n < KEY_COUNT; n++) begin
            if (!slot_pr[n] && (!any_new || (4'(n) > last_slot))) begin
                clr_mask = clr_mask | KEY_CODE[n];
            end
        end
    end

    assign serial_nx   = i_state.serial + new_cnt[2:0];
    assign serial_last = serial_nx - 3'd1;

    assign edge_hi = any_new ? KEY_CODE[last_slot] : i_state.edge_word[31:16];
    assign edge_lo = any_new
        ? ({8'd0, EDGE_FLAG} | {9'd0, serial_last, 4'd0} | {12'd0, KEY_NUMBER[last_slot]})
        : i_state.edge_word[15:0];

    always_comb begin
        o_state.pressed    = now_pr;
        o_state.serial     = serial_nx;
        o_state.edge_word  = {edge_hi & ~clr_mask, edge_lo};
        o_state.level_word = level;
    end

endmodule

// ----- rtl/keypad_edge_event_encoder.sv -----
// Top level of the keypad edge event encoder: handshakes, config and pipeline.
//
// Usage:
//  - s_axis carries one keypad poll per word: tdata[0] unit, tdata[12:1] raw keys.
//  - m_axis returns one word per poll: tdata[15:0] key level, tdata[47:16] key edge.
//  - The config channel (i_cfg_valid/o_cfg_ready, i_cfg_index, i_cfg_data) writes
//    flip_rows (index 0) and freeze (index 1); it is always ready. Write it only
//    while no poll is in flight.
//  - An accepted poll goes through the scan stage register, then the output register.
//  - Throughput: one poll per cycle while m_axis does not stall. The per-unit state
//    is read from the state memory at acceptance and written back (unless frozen)
//    as the poll leaves; a poll of that unit accepted then gets it via the bypass.
//  - Reset clears the config, the output and every unit's state (each entry
//    reads as zero until first written). s_axis_tready stays low during reset
//    and until the run flag is set after it.
//  - When m_axis stalls the finished word is held in the output register and
//    one further poll is taken and held in the scan stage; then s_axis_tready
//    drops until the output is taken.
//  - Units beyond the last one are mapped to the last unit.
module keypad_edge_event_encoder #(
    parameter int NUM_UNITS = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [0] unit, [12:1] raw_keys, [15:13] zero
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // [15:0] press_level, [47:16] press_event
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic        i_cfg_data
);
    import kee_pkg::*;

    localparam int AW = (NUM_UNITS > 1) ? $clog2(NUM_UNITS) : 1;
    localparam logic [AW-1:0] LAST_UNIT = AW'(NUM_UNITS - 1);

    logic          r_run;
    logic          r_flip;
    logic          r_freeze;
    logic          r_s1_valid;
    logic [AW-1:0] r_s1_unit;
    logic [11:0]   r_s1_keys;
    logic          r_out_valid;
    logic [15:0]   r_out_level;
    logic [31:0]   r_out_edge;

    logic          in_acc;
    logic          s1_move;
    logic [AW-1:0] in_unit;
    logic          wr_en;
    t_unit_state   rd_state;
    t_unit_state   upd_state;
    t_cfg_index    cfg_idx;

    assign s1_move       = r_s1_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = r_run && (!r_s1_valid || s1_move);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign in_unit       = (AW'(s_axis_tdata[0]) > LAST_UNIT) ? LAST_UNIT
                                                              : AW'(s_axis_tdata[0]);
    assign wr_en         = s1_move && !r_freeze;
    assign o_cfg_ready   = 1'b1;
    assign cfg_idx       = t_cfg_index'(i_cfg_index);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run    <= 1'b0;
            r_flip   <= 1'b0;
            r_freeze <= 1'b0;
        end else begin
            r_run <= 1'b1;
            if (i_cfg_valid) begin
                unique case (cfg_idx)
                    CFG_FLIP_ROWS: r_flip   <= i_cfg_data;
                    CFG_FREEZE:    r_freeze <= i_cfg_data;
                    default:       r_flip   <= r_flip;
                endcase
            end
        end
    end

    kee_state_mem #(
        .NUM_UNITS (NUM_UNITS),
        .AW        (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (in_acc),
        .i_rd_addr (in_unit),
        .o_rd_data (rd_state),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_s1_unit),
        .i_wr_data (upd_state)
    );

    kee_scan u_scan (
        .i_flip  (r_flip),
        .i_keys  (r_s1_keys),
        .i_state (rd_state),
        .o_state (upd_state)
    );

    // scan stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_acc) begin
            r_s1_valid <= 1'b1;
        end else if (s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_unit <= in_unit;
            r_s1_keys <= s_axis_tdata[12:1];
        end
    end

    // output register; frozen polls return the held words
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_move) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_out_level <= r_freeze ? rd_state.level_word : upd_state.level_word;
            r_out_edge  <= r_freeze ? rd_state.edge_word  : upd_state.edge_word;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_edge, r_out_level};

    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !s1_move |=> r_s1_valid && $stable(r_s1_unit) && $stable(r_s1_keys))
        else $error("scan stage word lost while stalled");

    a_acc_to_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_s1_valid && (r_s1_unit == $past(in_unit)))
        else $error("accepted poll did not reach scan stage");

    a_frozen_no_wr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_freeze && s1_move |=> (r_out_edge == $past(rd_state.edge_word)))
        else $error("frozen poll did not return held edge word");

endmodule

// ----- bench/tb_keypad_edge_event_encoder.sv -----
// Self-checking testbench for the keypad edge event encoder.
`timescale 1ns / 100ps

module tb_keypad_edge_event_encoder;
    import kee_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int UNITS       = 2;

    // Raw bit and key number of each scan slot (the two coincide)
    localparam logic [3:0] SLOT_KEY [12] = '{
        4'd0, 4'd1, 4'd5, 4'd9, 4'd2, 4'd6, 4'd10, 4'd3, 4'd7, 4'd11, 4'd8, 4'd4
    };
    localparam logic [15:0] SLOT_CODE [12] = '{
        16'h0100, 16'h0200, 16'h2000, 16'h0002, 16'h0400, 16'h4000,
        16'h0004, 16'h0800, 16'h8000, 16'h0008, 16'h0001, 16'h1000
    };
    // Key looked at by each slot with swapped rows
    localparam logic [3:0] SWAP_SLOT [12] = '{
        4'd11, 4'd7, 4'd8, 4'd9, 4'd4, 4'd5, 4'd6, 4'd1, 4'd2, 4'd3, 4'd10, 4'd0
    };

    typedef struct {
        logic [15:0] level;
        logic [31:0] edge_bits;
    } t_poll_result;

    class kee_scoreboard;
        bit           flip_rows;
        bit           freeze;
        logic [11:0]  pressed_before [UNITS];
        logic [2:0]   serial [UNITS];
        logic [31:0]  edge_held [UNITS];
        logic [15:0]  level_held [UNITS];
        t_poll_result awaited [$];
        int           errors;
        int           polls;
        int           checked;

        function new();
            for (int u = 0; u < UNITS; u++) begin
                pressed_before[u] = '0;
                serial[u]         = '0;
                edge_held[u]      = '0;
                level_held[u]     = '0;
            end
        endfunction

        // Scan one poll and queue the word the block should return
        function void note_poll(logic unit, logic [11:0] keys);
            logic [15:0]  level;
            logic [31:0]  edge_w;
            logic [2:0]   ser;
            logic [11:0]  prev_pr;
            logic [3:0]   k;
            t_poll_result res;
            polls++;
            if (!freeze) begin
                level   = '0;
                edge_w  = edge_held[unit];
                ser     = serial[unit];
                prev_pr = pressed_before[unit];
                for (int n = 0; n < 12; n++) begin
                    k = flip_rows ? SWAP_SLOT[n] : 4'(n);
                    if (keys[SLOT_KEY[k]]) begin
                        level |= SLOT_CODE[k];
                        if (!prev_pr[k]) begin
                            edge_w = {SLOT_CODE[n], 8'h00, 1'b1, ser, SLOT_KEY[n]};
                            ser    = ser + 3'd1;
                        end
                        prev_pr[k] = 1'b1;
                    end else begin
                        edge_w     = edge_w & ~{SLOT_CODE[n], 16'h0000};
                        prev_pr[k] = 1'b0;
                    end
                end
                level_held[unit]     = level;
                edge_held[unit]      = edge_w;
                serial[unit]         = ser;
                pressed_before[unit] = prev_pr;
            end
            res.level     = level_held[unit];
            res.edge_bits = edge_held[unit];
            awaited.push_back(res);
        endfunction

        function void check_word(logic [15:0] level, logic [31:0] edge_bits);
            t_poll_result res;
            checked++;
            if (awaited.size() == 0) begin
                $error("result word with nothing awaited: level %h edge %h", level, edge_bits);
                errors++;
                return;
            end
            res = awaited.pop_front();
            if (level !== res.level) begin
                $error("press_level: expected %h, got %h", res.level, level);
                errors++;
            end
            if (edge_bits !== res.edge_bits) begin
                $error("press_event: expected %h, got %h", res.edge_bits, edge_bits);
                errors++;
            end
        endfunction

        function int pending();
            return awaited.size();
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;    // [0] unit, [12:1] raw_keys, [15:13] zero
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;    // [15:0] press_level, [47:16] press_event
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    t_cfg_index  i_cfg_index;
    logic        i_cfg_data;

    kee_scoreboard sb = new();
    bit            calm;
    int            cycles;
    int            settings;
    logic [11:0]   last_keys [UNITS];

    keypad_edge_event_encoder #(.NUM_UNITS(UNITS)) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_word(m_axis_tdata[15:0], m_axis_tdata[47:16]);
    end

    // Result side: random stalls, except in calm stretches
    initial begin : sink
        int stall;
        m_axis_tready <= 1'b0;
        @(posedge i_rst_n);
        forever begin
            stall = calm ? 0 : $urandom_range(0, 8);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    task automatic send_poll(logic unit, logic [11:0] keys);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, keys, unit};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_poll(unit, keys);
        last_keys[unit] = keys;
    endtask

    // Stop sending and let every awaited word come back
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic program_mode(bit flip, bit frz);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_FLIP_ROWS;
        i_cfg_data  <= flip;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.flip_rows = flip;
        i_cfg_index <= CFG_FREEZE;
        i_cfg_data  <= frz;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.freeze = frz;
        i_cfg_valid <= 1'b0;
        settings++;
    endtask

    // Mostly small changes to the unit's last keys, so presses and releases interleave
    task automatic random_polls(int count);
        logic        unit;
        logic [11:0] keys;
        int          pick;
        for (int i = 0; i < count; i++) begin
            if (i % 60 == 0)
                calm = ($urandom_range(0, 3) == 0);
            unit = 1'($urandom_range(0, 1));
            pick = $urandom_range(0, 9);
            keys = last_keys[unit];
            if (pick <= 5) begin
                keys[$urandom_range(0, 11)] ^= 1'b1;
                if (pick >= 3)
                    keys[$urandom_range(0, 11)] ^= 1'b1;
            end else if (pick == 6) begin
                keys = 12'h000;
            end else if (pick == 7) begin
                keys = 12'hFFF;
            end else begin
                keys = 12'($urandom);
            end
            send_poll(unit, keys);
        end
    endtask

    initial begin
        cycles        <= 0;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        i_cfg_valid   <= 1'b0;
        i_cfg_index   <= CFG_FLIP_ROWS;
        i_cfg_data    <= 1'b0;
        calm          = 1'b0;
        settings      = 0;
        last_keys[0]  = '0;
        last_keys[1]  = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        program_mode(1'b0, 1'b0);
        // all keys at once wraps the serial; repeats give no new press
        send_poll(1'b0, 12'h000);
        send_poll(1'b0, 12'hFFF);
        send_poll(1'b0, 12'hFFF);
        send_poll(1'b0, 12'h000);
        send_poll(1'b0, 12'hFFF);
        send_poll(1'b1, 12'h001);
        send_poll(1'b1, 12'h800);
        send_poll(1'b1, 12'h555);
        send_poll(1'b1, 12'hAAA);
        send_poll(1'b1, 12'h000);
        for (int i = 0; i < 12; i++)
            send_poll(1'(i % 2), 12'(1 << i));
        drain();

        program_mode(1'b1, 1'b0);
        random_polls(280);
        drain();
        program_mode(1'b0, 1'b1);
        random_polls(60);
        drain();
        program_mode(1'b1, 1'b1);
        random_polls(60);
        drain();
        program_mode(1'b0, 1'b0);
        random_polls(150);
        drain();
        random_polls(150);
        drain();
        program_mode(1'b1, 1'b0);
        random_polls(130);
        drain();

        $display("Covered %0d polls of both units under %0d register settings,",
                 sb.polls, settings);
        $display("with freeze and swapped rows, %0d result words compared.", sb.checked);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
